// ===== hw/rtl/scol_pkg.sv =====
package scol_pkg;

    // parser modes, shared by the parser and the top level
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_LIGHT  = 3'd1,
        MODE_VOLUME = 3'd2,
        MODE_SYMBOL = 3'd3,
        MODE_MOTOR  = 3'd4,
        MODE_ENABLE = 3'd5,
        MODE_TOP    = 3'd6,
        MODE_FLASH  = 3'd7
    } t_mode;

    // configuration register indexes
    localparam logic [1:0] CFG_RISE_STEP = 2'd0;
    localparam logic [1:0] CFG_FALL_STEP = 2'd1;
    localparam logic [1:0] CFG_TOP_LIMIT = 2'd2;

    localparam int CFG_WIDTH   = 12;
    localparam int STEP_WIDTH  = 8;
    localparam int LIMIT_WIDTH = 12;
    localparam int POS_WIDTH   = 14;
    localparam int LIGHT_LEN   = 15;
    localparam int VOLUME_LEN  = 5;
    localparam int COUNT_WIDTH = 4;

    localparam logic [STEP_WIDTH-1:0]  RISE_STEP_RESET = 8'd20;
    localparam logic [STEP_WIDTH-1:0]  FALL_STEP_RESET = 8'd40;
    localparam logic [LIMIT_WIDTH-1:0] TOP_LIMIT_RESET = 12'd2000;

    // bits of the frame word that can ever be set
    localparam logic [31:0] FRAME_USED_MASK = 32'h3FFF_3F06;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;

    // committed groups after one word, parser to top level
    typedef struct packed {
        logic                  frame_load;
        t_mode                 mode;
        logic [LIGHT_LEN-1:0]  light;
        logic [VOLUME_LEN-1:0] volume;
        logic [2:0]            symbol;
        logic [2:0]            motor_en;
        logic [1:0]            enable;
        logic                  top;
        logic                  flash;
    } t_cmd_stat;

    // motor step outcome, motor unit to top level
    typedef struct packed {
        logic up;
        logic down;
        logic spin;
    } t_motor_stat;

    function automatic t_mode letter_mode(input logic [7:0] c);
        t_mode m;
        case (c)
            8'h6C:   m = MODE_LIGHT;   // l
            8'h76:   m = MODE_VOLUME;  // v
            8'h73:   m = MODE_SYMBOL;  // s
            8'h6D:   m = MODE_MOTOR;   // m
            8'h65:   m = MODE_ENABLE;  // e
            8'h74:   m = MODE_TOP;     // t
            8'h66:   m = MODE_FLASH;   // f
            default: m = MODE_IDLE;
        endcase
        return m;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] group_len(input t_mode m);
        logic [COUNT_WIDTH-1:0] n;
        unique case (m)
            MODE_LIGHT:  n = 4'd15;
            MODE_VOLUME: n = 4'd5;
            MODE_SYMBOL: n = 4'd3;
            MODE_MOTOR:  n = 4'd3;
            MODE_ENABLE: n = 4'd2;
            MODE_TOP:    n = 4'd1;
            MODE_FLASH:  n = 4'd1;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

    // serial chain image, serial byte k lands in word byte 3-k
    function automatic logic [31:0] pack_frame(
        input logic [LIGHT_LEN-1:0]  light,
        input logic [VOLUME_LEN-1:0] volume,
        input logic [1:0]            enable
    );
        logic [31:0] ser;
        ser        = '0;
        ser[5:0]   = light[5:0];
        ser[16:8]  = light[14:6];
        ser[21:17] = volume;
        ser[26:25] = enable;
        return {ser[7:0], ser[15:8], ser[23:16], ser[31:24]};
    endfunction

endpackage

// ===== hw/rtl/scol_cmd_parser.sv =====
module scol_cmd_parser
    import scol_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  logic      i_opcode,
    input  logic [7:0] i_rx_byte,
    output t_cmd_stat o_stat
);

    t_mode                  r_mode,    n_mode;
    logic [COUNT_WIDTH-1:0] r_count,   n_count;
    logic [LIGHT_LEN-1:0]   r_staging, n_staging;
    logic [LIGHT_LEN-1:0]   r_light,   n_light;
    logic [VOLUME_LEN-1:0]  r_volume,  n_volume;
    logic [2:0]             r_symbol,  n_symbol;
    logic [2:0]             r_motor,   n_motor;
    logic [1:0]             r_enable,  n_enable;
    logic                   r_top,     n_top;
    logic                   r_flash,   n_flash;
    logic                   n_load;

    always_comb begin
        t_mode                  mode_eff;
        logic                   digit;
        logic [COUNT_WIDTH-1:0] cnt_inc;
        n_mode    = r_mode;
        n_count   = r_count;
        n_staging = r_staging;
        n_light   = r_light;
        n_volume  = r_volume;
        n_symbol  = r_symbol;
        n_motor   = r_motor;
        n_enable  = r_enable;
        n_top     = r_top;
        n_flash   = r_flash;
        n_load    = 1'b0;
        digit     = (i_rx_byte == CHAR_ZERO) || (i_rx_byte == CHAR_ONE);
        // a non-digit aborts an open group and is then taken as a command
        mode_eff  = (r_mode != MODE_IDLE && !digit) ? MODE_IDLE : r_mode;
        cnt_inc   = r_count + 4'd1;
        if (i_fire && i_opcode) begin
            if (mode_eff != MODE_IDLE) begin
                if (r_count < 4'(LIGHT_LEN)) begin
                    n_staging[r_count] = i_rx_byte[0];
                end
                if (cnt_inc >= group_len(mode_eff)) begin
                    n_mode  = MODE_IDLE;
                    n_count = '0;
                    unique case (mode_eff)
                        MODE_LIGHT: begin
                            n_light = n_staging;
                            n_load  = 1'b1;
                        end
                        MODE_VOLUME: begin
                            n_volume = n_staging[VOLUME_LEN-1:0];
                            n_load   = 1'b1;
                        end
                        MODE_SYMBOL: n_symbol = n_staging[2:0];
                        MODE_MOTOR: begin
                            n_motor = n_staging[2:0];
                            n_load  = 1'b1;
                        end
                        MODE_ENABLE: begin
                            n_enable = n_staging[1:0];
                            n_load   = 1'b1;
                        end
                        MODE_TOP:   n_top   = n_staging[0];
                        default:    n_flash = n_staging[0];
                    endcase
                end else begin
                    n_count = cnt_inc;
                end
            end else begin
                n_mode  = letter_mode(i_rx_byte);
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_count   <= '0;
            r_staging <= '0;
            r_light   <= '0;
            r_volume  <= '0;
            r_symbol  <= '0;
            r_motor   <= '0;
            r_enable  <= '0;
            r_top     <= 1'b0;
            r_flash   <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_staging <= n_staging;
            r_light   <= n_light;
            r_volume  <= n_volume;
            r_symbol  <= n_symbol;
            r_motor   <= n_motor;
            r_enable  <= n_enable;
            r_top     <= n_top;
            r_flash   <= n_flash;
        end
    end

    assign o_stat = '{
        frame_load: n_load,
        mode:       n_mode,
        light:      n_light,
        volume:     n_volume,
        symbol:     n_symbol,
        motor_en:   n_motor,
        enable:     n_enable,
        top:        n_top,
        flash:      n_flash
    };

endmodule

// ===== hw/rtl/scol_motor.sv =====
module scol_motor
    import scol_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [2:0]             i_motor_en,
    input  logic [STEP_WIDTH-1:0]  i_rise_step,
    input  logic [STEP_WIDTH-1:0]  i_fall_step,
    input  logic [LIMIT_WIDTH-1:0] i_top_limit,
    output t_motor_stat            o_stat
);

    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [POS_WIDTH-1:0] limit_ext, rise_ext, fall_ext;
    logic                 step_up, step_down;

    assign limit_ext = POS_WIDTH'(i_top_limit);
    assign rise_ext  = POS_WIDTH'(i_rise_step);
    assign fall_ext  = POS_WIDTH'(i_fall_step);

    assign step_up   = i_motor_en[0] && (r_pos < limit_ext);
    assign step_down = !step_up && i_motor_en[1] && (r_pos != '0);

    always_comb begin
        n_pos = r_pos;
        if (i_fire) begin
            if (step_up) begin
                n_pos = r_pos + rise_ext;
            end else if (step_down) begin
                // saturate at zero on overshoot
                n_pos = (r_pos > fall_ext) ? (r_pos - fall_ext) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_stat = '{
        up:   step_up,
        down: step_down,
        spin: i_motor_en[2] && (n_pos >= limit_ext)
    };

endmodule

// ===== hw/rtl/serial_command_output_latch.sv =====
// serial command parser and output latch for a lamp/volume chain, symbol and
// top/flash lamps and a motor lift with servo. each input word is a tick,
// optionally preceded by a received byte (i_opcode = 1). letters l v s m e t f
// open a group of 15 5 3 3 2 1 1 bits, digits '0'/'1' fill it from bit 0 up,
// and the group is committed when full; any other byte drops an open group
// and is taken as a new command. every word also takes one motor step.
// each input word yields exactly one result word, passing through the input
// register and then the result register: two-stage pipeline, one word per
// clock sustained while the result side is not held. a held result keeps the
// input register full, and the input side stalls only once both stages hold a
// word. configuration writes (0 rise step, 1 fall step, 2 top limit) land at
// the write edge and must only be issued while no word is in flight.
module serial_command_output_latch
    import scol_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [7:0]           i_rx_byte,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_frame_word,
    output logic                 o_frame_load,
    output logic [2:0]           o_symbol_lines,
    output logic                 o_top_light,
    output logic                 o_flash_light,
    output logic                 o_motor_up_pulse,
    output logic                 o_motor_down_pulse,
    output logic                 o_spin_cmd,
    output logic [2:0]           o_mode_now,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    // configuration registers
    logic [STEP_WIDTH-1:0]  r_rise_step;
    logic [STEP_WIDTH-1:0]  r_fall_step;
    logic [LIMIT_WIDTH-1:0] r_top_limit;

    // input register
    logic       r_in_valid;
    logic       r_opcode;
    logic [7:0] r_rx_byte;

    // result register
    logic        r_out_valid;
    logic [31:0] r_frame_word;
    logic        r_frame_load;
    logic [2:0]  r_symbol_lines;
    logic        r_top_light;
    logic        r_flash_light;
    logic        r_up;
    logic        r_down;
    logic        r_spin;
    t_mode       r_mode_now;

    logic        advance;   // result register can take a new word
    logic        fire;      // word in the input register is processed
    t_cmd_stat   cmd_stat;
    t_motor_stat motor_stat;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    // input stage refills whenever its word moves on, so no bubble
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_step <= RISE_STEP_RESET;
            r_fall_step <= FALL_STEP_RESET;
            r_top_limit <= TOP_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RISE_STEP: r_rise_step <= i_cfg_data[STEP_WIDTH-1:0];
                CFG_FALL_STEP: r_fall_step <= i_cfg_data[STEP_WIDTH-1:0];
                CFG_TOP_LIMIT: r_top_limit <= i_cfg_data[LIMIT_WIDTH-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_opcode  <= i_opcode;
            r_rx_byte <= i_rx_byte;
        end
    end

    scol_cmd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_opcode  (r_opcode),
        .i_rx_byte (r_rx_byte),
        .o_stat    (cmd_stat)
    );

    // motor sees the enable bits as committed by this same word
    scol_motor u_motor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_motor_en  (cmd_stat.motor_en),
        .i_rise_step (r_rise_step),
        .i_fall_step (r_fall_step),
        .i_top_limit (r_top_limit),
        .o_stat      (motor_stat)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_frame_word   <= pack_frame(cmd_stat.light, cmd_stat.volume, cmd_stat.enable);
            r_frame_load   <= cmd_stat.frame_load;
            r_symbol_lines <= cmd_stat.symbol;
            r_top_light    <= cmd_stat.top;
            r_flash_light  <= cmd_stat.flash;
            r_up           <= motor_stat.up;
            r_down         <= motor_stat.down;
            r_spin         <= motor_stat.spin;
            r_mode_now     <= cmd_stat.mode;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame_word       = r_frame_word;
    assign o_frame_load       = r_frame_load;
    assign o_symbol_lines     = r_symbol_lines;
    assign o_top_light        = r_top_light;
    assign o_flash_light      = r_flash_light;
    assign o_motor_up_pulse   = r_up;
    assign o_motor_down_pulse = r_down;
    assign o_spin_cmd         = r_spin;
    assign o_mode_now         = r_mode_now;

    // up and down steps are exclusive
    a_step_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_up && r_down))
        else $error("motor up and down pulse in the same word");

    // unused chain positions always read zero
    a_frame_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_frame_word & ~FRAME_USED_MASK) == 32'h0))
        else $error("frame word has an unused bit set");

    // a commit always closes the group
    a_load_closes_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_frame_load) |-> (r_mode_now == MODE_IDLE))
        else $error("frame load with a group still open");

    // an accepted word is held in the input register next cycle
    a_accept_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted word lost from input register");

endmodule

// ===== verif/serial_command_output_latch_test.sv =====
module serial_command_output_latch_test
    import scol_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 4;     // pipeline is two deep, allow a little more
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving on either side
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_WORDS    = 100;
    localparam int MAX_GAP        = 30;
    localparam int DIRECTED_ROWS  = 32;

    // command letters the random part picks from, one byte each
    localparam logic [55:0] CMD_LETTERS = "lvsmetf";

    // one result word as the block presents it
    typedef struct packed {
        logic [31:0] frame_word;
        logic        frame_load;
        logic [2:0]  symbol_lines;
        logic        top_light;
        logic        flash_light;
        logic        motor_up_pulse;
        logic        motor_down_pulse;
        logic        spin_cmd;
        t_mode       mode_now;
    } t_latch_result;

    // directed table: either an input word or a register write
    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [1:0]           cfg_index;
        logic [CFG_WIDTH-1:0] cfg_value;
        logic                 opcode;
        logic [7:0]           rx_byte;
        logic                 typed;      // use the hand-written result below
        t_latch_result        want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_opcode;
    logic [7:0]           i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [31:0]          o_frame_word;
    logic                 o_frame_load;
    logic [2:0]           o_symbol_lines;
    logic                 o_top_light;
    logic                 o_flash_light;
    logic                 o_motor_up_pulse;
    logic                 o_motor_down_pulse;
    logic                 o_spin_cmd;
    logic [2:0]           o_mode_now;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [CFG_WIDTH-1:0] i_cfg_data;

    serial_command_output_latch uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_rx_byte          (i_rx_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_frame_word       (o_frame_word),
        .o_frame_load       (o_frame_load),
        .o_symbol_lines     (o_symbol_lines),
        .o_top_light        (o_top_light),
        .o_flash_light      (o_flash_light),
        .o_motor_up_pulse   (o_motor_up_pulse),
        .o_motor_down_pulse (o_motor_down_pulse),
        .o_spin_cmd         (o_spin_cmd),
        .o_mode_now         (o_mode_now),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // predictor copy of the block's state and registers
    t_mode            sim_mode;
    logic [3:0]       sim_count;
    logic [14:0]      sim_staging;
    logic [14:0]      sim_light;
    logic [4:0]       sim_volume;
    logic [2:0]       sim_symbol;
    logic [2:0]       sim_motor_en;   // bit 0 up, bit 1 down, bit 2 servo
    logic [1:0]       sim_enable;
    logic             sim_top;
    logic             sim_flash;
    logic [13:0]      sim_pos;
    logic [7:0]       cfg_rise;
    logic [7:0]       cfg_fall;
    logic [11:0]      cfg_limit;

    t_latch_result    latch_expected [$];
    t_stim_row        directed_rows [DIRECTED_ROWS];

    int               idle_pct;       // sender gap chance per cycle, percent
    int               stall_pct;      // receiver stall chance per cycle, percent
    int               words_sent;
    int               result_count;
    int               mismatches;

    // free-running clock, 10 ns
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // digits needed to fill each group
    function automatic logic [3:0] group_size(input t_mode m);
        case (m)
            MODE_LIGHT:  return 4'd15;
            MODE_VOLUME: return 4'd5;
            MODE_SYMBOL: return 4'd3;
            MODE_MOTOR:  return 4'd3;
            MODE_ENABLE: return 4'd2;
            MODE_TOP:    return 4'd1;
            MODE_FLASH:  return 4'd1;
            default:     return 4'd0;
        endcase
    endfunction

    function automatic t_mode decode_command(input logic [7:0] c);
        case (c)
            "l":     return MODE_LIGHT;
            "v":     return MODE_VOLUME;
            "s":     return MODE_SYMBOL;
            "m":     return MODE_MOTOR;
            "e":     return MODE_ENABLE;
            "t":     return MODE_TOP;
            "f":     return MODE_FLASH;
            default: return MODE_IDLE;
        endcase
    endfunction

    // advance the predicted state by one accepted word and form its result
    task automatic predict_word(input logic op, input logic [7:0] c,
                                output t_latch_result r);
        logic is_digit;
        logic load;
        logic up;
        logic down;
        load = 1'b0;
        up   = 1'b0;
        down = 1'b0;
        if (op) begin
            is_digit = (c == CHAR_ZERO) || (c == CHAR_ONE);
            // a non-digit drops the open group and is then parsed as a command
            if (sim_mode != MODE_IDLE && !is_digit) begin
                sim_mode  = MODE_IDLE;
                sim_count = '0;
            end
            if (sim_mode != MODE_IDLE) begin
                if (sim_count < 4'd15)
                    sim_staging[sim_count] = c[0];
                sim_count = sim_count + 4'd1;
                if (sim_count >= group_size(sim_mode)) begin
                    case (sim_mode)
                        MODE_LIGHT: begin
                            sim_light = sim_staging;
                            load      = 1'b1;
                        end
                        MODE_VOLUME: begin
                            sim_volume = sim_staging[4:0];
                            load       = 1'b1;
                        end
                        MODE_SYMBOL: sim_symbol = sim_staging[2:0];
                        MODE_MOTOR: begin
                            sim_motor_en = sim_staging[2:0];
                            load         = 1'b1;
                        end
                        MODE_ENABLE: begin
                            sim_enable = sim_staging[1:0];
                            load       = 1'b1;
                        end
                        MODE_TOP:   sim_top   = sim_staging[0];
                        MODE_FLASH: sim_flash = sim_staging[0];
                        default: ;
                    endcase
                    sim_mode  = MODE_IDLE;
                    sim_count = '0;
                end
            end else begin
                sim_mode  = decode_command(c);
                sim_count = '0;
            end
        end

        // one motor step per word, upward motion wins
        if (sim_motor_en[0] && sim_pos < 14'(cfg_limit)) begin
            sim_pos = sim_pos + 14'(cfg_rise);
            up      = 1'b1;
        end else if (sim_motor_en[1] && sim_pos != '0) begin
            sim_pos = (sim_pos > 14'(cfg_fall)) ? sim_pos - 14'(cfg_fall) : '0;
            down    = 1'b1;
        end

        // chain image: serial byte k sits in word byte 3-k
        r.frame_word       = {2'b00, sim_light[5:0],
                              sim_light[13:6],
                              2'b00, sim_volume, sim_light[14],
                              5'b00000, sim_enable, 1'b0};
        r.frame_load       = load;
        r.symbol_lines     = sim_symbol;
        r.top_light        = sim_top;
        r.flash_light      = sim_flash;
        r.motor_up_pulse   = up;
        r.motor_down_pulse = down;
        r.spin_cmd         = sim_motor_en[2] && (sim_pos >= 14'(cfg_limit));
        r.mode_now         = sim_mode;
    endtask

    // ---------------------------------------------------------------
    // directed table helpers
    // ---------------------------------------------------------------

    function automatic t_stim_row word_row(input logic op, input logic [7:0] c);
        t_stim_row r;
        r         = '0;
        r.kind    = ROW_WORD;
        r.opcode  = op;
        r.rx_byte = c;
        return r;
    endfunction

    function automatic t_stim_row checked_row(input logic op, input logic [7:0] c,
                                              input t_latch_result want);
        t_stim_row r;
        r       = word_row(op, c);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [1:0] idx,
                                          input logic [CFG_WIDTH-1:0] value);
        t_stim_row r;
        r           = '0;
        r.kind      = ROW_CFG;
        r.cfg_index = idx;
        r.cfg_value = value;
        return r;
    endfunction

    // frame, load, symbol, top, flash, up, down, spin, mode
    function automatic t_latch_result outcome(
        input logic [31:0] frame, input logic load, input logic [2:0] symbol,
        input logic top, input logic flash, input logic up, input logic down,
        input logic spin, input t_mode mode
    );
        t_latch_result r;
        r = '{frame, load, symbol, top, flash, up, down, spin, mode};
        return r;
    endfunction

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offer one word, hold it until taken, then record what should come back
    task automatic send_word(input logic op, input logic [7:0] c,
                             input logic typed, input t_latch_result want);
        t_latch_result predicted;
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_rx_byte  <= c;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        // the state always moves, even where the row carries its own result
        predict_word(op, c, predicted);
        latch_expected.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    // stop offering words and let every pending result drain out
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (latch_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only ever issued with the pipeline empty
    task automatic write_register(input logic [1:0] idx,
                                  input logic [CFG_WIDTH-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_RISE_STEP: cfg_rise  = value[7:0];
            CFG_FALL_STEP: cfg_fall  = value[7:0];
            CFG_TOP_LIMIT: cfg_limit = value[11:0];
            default: ;
        endcase
        // wait with the write strobe low so a following write starts on a fresh edge
        @(posedge i_clk);
    endtask

    // one random sequence: mostly full groups, some cut short, some noise
    task automatic random_burst();
        int         pick;
        int         len;
        int         cut;
        int         k;
        logic [7:0] letter;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            letter = CMD_LETTERS[8 * $urandom_range(0, 6) +: 8];
            len    = int'(group_size(decode_command(letter)));
            // under 60: complete group, otherwise broken off early
            cut    = (pick < 60) ? len : $urandom_range(0, len - 1);
            send_word(1'b1, letter, 1'b0, '0);
            for (k = 0; k < cut; k++) begin
                // ticks inside a group leave the parser alone
                if ($urandom_range(0, 99) < 15)
                    send_word(1'b0, 8'($urandom), 1'b0, '0);
                send_word(1'b1, $urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO, 1'b0, '0);
            end
            if (cut < len)
                send_word(1'b1, 8'($urandom), 1'b0, '0);
        end else if (pick < 90) begin
            send_word(1'b0, 8'($urandom), 1'b0, '0);
        end else begin
            send_word(1'b1, 8'($urandom), 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // receiver side and checking
    // ---------------------------------------------------------------

    // random back-pressure at the rate the current phase asks for
    initial begin : result_sink
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input int word_no,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                      word_no, field, got, want));
    endtask

    // compare every taken result word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_latch_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (latch_expected.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with nothing pending",
                                          result_count));
            end else begin
                want = latch_expected.pop_front();
                check_field("frame_word", result_count, o_frame_word, want.frame_word);
                check_field("frame_load", result_count, 32'(o_frame_load),
                            32'(want.frame_load));
                check_field("symbol_lines", result_count, 32'(o_symbol_lines),
                            32'(want.symbol_lines));
                check_field("top_light", result_count, 32'(o_top_light),
                            32'(want.top_light));
                check_field("flash_light", result_count, 32'(o_flash_light),
                            32'(want.flash_light));
                check_field("motor_up_pulse", result_count, 32'(o_motor_up_pulse),
                            32'(want.motor_up_pulse));
                check_field("motor_down_pulse", result_count, 32'(o_motor_down_pulse),
                            32'(want.motor_down_pulse));
                check_field("spin_cmd", result_count, 32'(o_spin_cmd),
                            32'(want.spin_cmd));
                check_field("mode_now", result_count, 32'(o_mode_now),
                            32'(want.mode_now));
            end
        end
    end

    // hang guard: ends the run once nothing has moved for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        int                   phase;
        int                   phase_start;
        logic [CFG_WIDTH-1:0] rise_val;
        logic [CFG_WIDTH-1:0] fall_val;
        logic [CFG_WIDTH-1:0] limit_val;

        // every input known from time zero, reset held low
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_opcode    <= 1'b0;
        i_rx_byte   <= 8'h00;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_RISE_STEP;
        i_cfg_data  <= '0;
        idle_pct     = 0;
        stall_pct    = 0;
        words_sent   = 0;
        result_count = 0;
        mismatches   = 0;

        // predictor starts from the reset state
        sim_mode     = MODE_IDLE;
        sim_count    = '0;
        sim_staging  = '0;
        sim_light    = '0;
        sim_volume   = '0;
        sim_symbol   = '0;
        sim_motor_en = '0;
        sim_enable   = '0;
        sim_top      = 1'b0;
        sim_flash    = 1'b0;
        sim_pos      = '0;
        cfg_rise     = RISE_STEP_RESET;
        cfg_fall     = FALL_STEP_RESET;
        cfg_limit    = TOP_LIMIT_RESET;

        // directed words, reset register values to begin with
        directed_rows = '{
            // fresh out of reset: nothing committed, parser idle
            checked_row(1'b1, 8'h00, '0),          // unknown byte, lowest code
            checked_row(1'b1, 8'hFF, '0),          // unknown byte, highest code
            checked_row(1'b1, CHAR_ONE, '0),       // digit with no group open
            checked_row(1'b0, 8'hFF, '0),          // tick, byte must be ignored
            // each letter opens a group; the next letter aborts the previous one
            word_row(1'b1, "l"),
            word_row(1'b1, CHAR_ONE),
            word_row(1'b1, "v"),
            word_row(1'b1, "e"),
            word_row(1'b1, CHAR_ONE),
            word_row(1'b1, "s"),
            word_row(1'b1, CHAR_ONE),
            word_row(1'b1, "b"),                   // abort, and b itself does nothing
            word_row(1'b1, "t"),
            word_row(1'b1, CHAR_ONE),              // top lamp on
            word_row(1'b1, "f"),
            word_row(1'b1, CHAR_ONE),              // flash lamp on
            // motor up from zero, then down-only with a step larger than the position
            cfg_row(CFG_FALL_STEP, 12'd255),
            word_row(1'b1, "m"),
            word_row(1'b1, CHAR_ONE),
            word_row(1'b1, CHAR_ONE),
            word_row(1'b1, CHAR_ONE),              // up, down, servo all enabled
            word_row(1'b1, "m"),
            word_row(1'b1, CHAR_ZERO),
            word_row(1'b1, CHAR_ONE),
            checked_row(1'b1, CHAR_ZERO,           // 80 down by 255 clamps at zero
                        outcome(32'h0, 1'b1, 3'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                                MODE_IDLE)),
            // zero rise step still pulses but leaves the position alone
            cfg_row(CFG_RISE_STEP, 12'd0),
            word_row(1'b1, "m"),
            word_row(1'b1, CHAR_ONE),
            word_row(1'b1, CHAR_ZERO),
            checked_row(1'b1, CHAR_ONE,
                        outcome(32'h0, 1'b1, 3'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                                MODE_IDLE)),
            // zero top limit: no upward move, servo spins on its enable alone
            cfg_row(CFG_TOP_LIMIT, 12'd0),
            checked_row(1'b0, 8'h00,
                        outcome(32'h0, 1'b0, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                                MODE_IDLE))
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_for_results();
                write_register(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
            end else begin
                send_word(directed_rows[i].opcode, directed_rows[i].rx_byte,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // random phases: new register setting and idling pattern each time,
        // with the sender pausing for a full drain at every boundary
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_for_results();
            case (phase)
                0: begin
                    rise_val  = 12'd20;
                    fall_val  = 12'd40;
                    limit_val = 12'd2000;
                end
                1: begin
                    rise_val  = 12'd255;
                    fall_val  = 12'd255;
                    limit_val = 12'd4095;
                end
                2: begin
                    rise_val  = 12'd1;
                    fall_val  = 12'd1;
                    limit_val = 12'd1;
                end
                3: begin
                    rise_val  = 12'd0;
                    fall_val  = 12'd0;
                    limit_val = 12'd0;
                end
                4: begin
                    rise_val  = 12'd1;
                    fall_val  = 12'd255;
                    limit_val = 12'd300;
                end
                default: begin
                    rise_val  = 12'($urandom_range(0, 255));
                    fall_val  = 12'($urandom_range(0, 255));
                    limit_val = 12'($urandom_range(0, 4095));
                end
            endcase
            write_register(CFG_RISE_STEP, rise_val);
            write_register(CFG_FALL_STEP, fall_val);
            write_register(CFG_TOP_LIMIT, limit_val);

            // no idling, sender idle, receiver stalling, both
            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 50;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 50;
                end
                default: begin
                    idle_pct  = 25;
                    stall_pct = 25;
                end
            endcase

            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
                random_burst();
        end

        // everything sent: drain, settle, verdict
        wait_for_results();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/scol_pkg.sv
hw/rtl/scol_cmd_parser.sv
hw/rtl/scol_motor.sv
hw/rtl/serial_command_output_latch.sv
verif/serial_command_output_latch_test.sv
